FILE: sv/lpcp_pkg.sv
package lpcp_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int COEF_W     = 32;
	localparam int CAM_W      = 32;
	localparam int PIX_W      = 16;
	localparam int CFG_W      = 14;
	localparam int IDX_W      = 5;
	localparam int EXT_COUNT  = 16;
	localparam int INTR_COUNT = 12;
	localparam int COEF_COUNT = 28;
	localparam int INTR_BASE  = 16;

	localparam int S_DATA_W = 136;
	localparam int M_DATA_W = 128;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd480;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// data that rides along the divider pipeline untouched
	typedef struct packed {
		logic signed [CAM_W-1:0] cam_x;
		logic signed [CAM_W-1:0] cam_y;
		logic signed [CAM_W-1:0] cam_z;
		logic                    neg_col;
		logic                    neg_row;
		logic                    zero;
	} side_t;

endpackage

FILE: sv/lpcp_div.sv
module lpcp_div #(
	parameter int AW = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [AW-1:0]            a_col,
	input  logic [AW-1:0]            a_row,
	input  logic [AW-1:0]            d,
	input  lpcp_pkg::side_t          side_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [lpcp_pkg::PIX_W-1:0] q_col,
	output logic [lpcp_pkg::PIX_W-1:0] q_row,
	output logic                     ovf_col,
	output logic                     ovf_row,
	output lpcp_pkg::side_t          side_out
);
	import lpcp_pkg::*;

	localparam int QW = PIX_W;
	localparam int XW = AW + QW;

	// stage 0 checks quotient overflow, stages 1..QW restore one quotient bit each
	logic          v_s   [0:QW];
	logic          ce    [0:QW];
	logic [AW-1:0] rc_s  [0:QW];
	logic [AW-1:0] rr_s  [0:QW];
	logic [AW-1:0] d_s   [0:QW];
	logic [QW-1:0] qc_s  [0:QW];
	logic [QW-1:0] qr_s  [0:QW];
	logic          oc_s  [0:QW];
	logic          ovr_s [0:QW];
	side_t         side_s[0:QW];

	assign ce[QW]   = !v_s[QW] || out_ready;
	assign in_ready = ce[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ce[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce[0]) begin
			rc_s[0]   <= a_col;
			rr_s[0]   <= a_row;
			d_s[0]    <= d;
			qc_s[0]   <= '0;
			qr_s[0]   <= '0;
			oc_s[0]   <= {{QW{1'b0}}, a_col} >= {d, {QW{1'b0}}};
			ovr_s[0]  <= {{QW{1'b0}}, a_row} >= {d, {QW{1'b0}}};
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [XW-1:0] dsh, rcx, rrx, dfc, dfr;
		logic          gec, ger;

		if (j < QW) begin : g_ce
			assign ce[j] = !v_s[j] || ce[j+1];
		end
		if (j == 1) begin : g_ce0
			assign ce[0] = !v_s[0] || ce[1];
		end

		assign dsh = XW'(d_s[j-1]) << (QW - j);
		assign rcx = XW'(rc_s[j-1]);
		assign rrx = XW'(rr_s[j-1]);
		assign gec = rcx >= dsh;
		assign ger = rrx >= dsh;
		assign dfc = rcx - dsh;
		assign dfr = rrx - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (ce[j]) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce[j]) begin
				rc_s[j]   <= gec ? dfc[AW-1:0] : rc_s[j-1];
				rr_s[j]   <= ger ? dfr[AW-1:0] : rr_s[j-1];
				qc_s[j]   <= qc_s[j-1] | (QW'(gec) << (QW - j));
				qr_s[j]   <= qr_s[j-1] | (QW'(ger) << (QW - j));
				d_s[j]    <= d_s[j-1];
				oc_s[j]   <= oc_s[j-1];
				ovr_s[j]  <= ovr_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign q_col     = qc_s[QW];
	assign q_row     = qr_s[QW];
	assign ovf_col   = oc_s[QW];
	assign ovf_row   = ovr_s[QW];
	assign side_out  = side_s[QW];

endmodule

FILE: sv/lidar_point_camera_projection.sv
// Lidar point to camera pixel projection, pinhole model, signed fixed point with
// FRAC_BITS fraction bits.
// Slave stream: tuser[0] is the kind. A coefficient-write transaction (kind 0)
// stores one of 28 coefficients (0-15 extrinsic, 16-27 intrinsic, row-major);
// it flows down the pipeline in order and yields no result. A point transaction
// (kind 1) yields exactly one master transaction with the camera point, the
// pixel and the in-view / depth-valid flags.
// Config port: cfg_we writes image width (index 0) or height (index 1) at once;
// write it only while the block is idle.
// Throughput: one transaction per cycle while m_tready is high. Pipeline: 26 register
// stages (8 for the input register and the two matrix products,
// 17 for the bit-per-stage pixel divider, 1 output register).
// Stalls: each stage holds when it is full and the next one cannot take data,
// so bubbles collapse and s_tready stays high while empty stages remain.
// Reset clears the pipeline valids and loads width 640, height 480. The
// coefficient table is not reset: every coefficient must be written before the
// first point.
module lidar_point_camera_projection #(
	parameter int FRAC_BITS = lpcp_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// coef_index[4:0], coef_value[36:5], point_x[68:37], point_y[100:69],
	// point_z[132:101], zero pad
	input  logic [lpcp_pkg::S_DATA_W-1:0]     s_tdata,
	// kind[0]
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cam_x[31:0], cam_y[63:32], cam_z[95:64], pixel_col[111:96], pixel_row[127:112]
	output logic [lpcp_pkg::M_DATA_W-1:0]     m_tdata,
	// in_view[0], depth_valid[1]
	output logic [1:0]                        m_tuser,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [lpcp_pkg::CFG_W-1:0]        cfg_data
);
	import lpcp_pkg::*;

	localparam int PW = 2 * COEF_W;     // one exact product
	localparam int SW = PW + 1;         // pair sum
	localparam int TW = PW + 2;         // four-term sum
	localparam int UW = TW - FRAC_BITS; // floored intrinsic result

	localparam logic signed [CAM_W-1:0] CAM_MAX = {1'b0, {(CAM_W-1){1'b1}}};
	localparam logic signed [CAM_W-1:0] CAM_MIN = {1'b1, {(CAM_W-1){1'b0}}};

	// coefficient storage, no reset
	logic signed [COEF_W-1:0] ext_q  [0:EXT_COUNT-1];
	logic signed [COEF_W-1:0] intr_q [0:INTR_COUNT-1];

	logic [CFG_W-1:0] width_q, height_q;

	logic ce1, ce2, ce3, ce4, ce5, ce6, ce7, ce8, ce9;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// s1: input register
	logic                     kind_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [COEF_W-1:0] val_s1;
	logic signed [COEF_W-1:0] pt_s1 [0:2];

	// s2..s4: extrinsic product, pair sums, floor and saturate
	logic                     kind_s2, kind_s3, kind_s4;
	logic [IDX_W-1:0]         idx_s2, idx_s3, idx_s4;
	logic signed [COEF_W-1:0] val_s2, val_s3, val_s4;
	logic signed [PW-1:0]     prod_s2 [0:15];
	logic signed [SW-1:0]     ps_s3   [0:7];
	logic signed [CAM_W-1:0]  cam_s4  [0:3];

	// s5..s8: intrinsic product, pair sums, floor, magnitude
	logic signed [PW-1:0]     prod_s5 [0:11];
	logic signed [SW-1:0]     ps_s6   [0:5];
	logic signed [UW-1:0]     uvw_s7  [0:2];
	logic [UW-1:0]            mag_s8  [0:2];
	logic signed [CAM_W-1:0]  cam_s5 [0:2];
	logic signed [CAM_W-1:0]  cam_s6 [0:2];
	logic signed [CAM_W-1:0]  cam_s7 [0:2];
	side_t                    side_s8;

	// s9: output register
	logic [M_DATA_W-1:0] dat_s9;
	logic [1:0]          usr_s9;

	// divider interface
	logic             div_in_rdy, div_out_v;
	logic [PIX_W-1:0] q_col, q_row;
	logic             ovf_col, ovf_row;
	side_t            side_d;

	// combinational stage results
	logic signed [PW-1:0]    prod_c  [0:15];
	logic signed [SW-1:0]    ps3_c   [0:7];
	logic signed [CAM_W-1:0] cam_c   [0:3];
	logic signed [PW-1:0]    prod5_c [0:11];
	logic signed [SW-1:0]    ps6_c   [0:5];
	logic signed [UW-1:0]    uvw_c   [0:2];
	logic signed [TW-1:0]    tot4_c  [0:3];
	logic signed [TW-1:0]    sh4_c   [0:3];
	logic signed [TW-1:0]    tot7_c  [0:2];
	logic signed [TW-1:0]    sh7_c   [0:2];
	logic [UW-1:0]           mag_c   [0:2];
	logic signed [PIX_W-1:0] col_c, row_c;
	logic                    view_c;

	// handshake chain, stage loads when empty or when its successor loads
	assign ce9      = !v_s9 || m_tready;
	assign ce8      = !v_s8 || div_in_rdy;
	assign ce7      = !v_s7 || ce8;
	assign ce6      = !v_s6 || ce7;
	assign ce5      = !v_s5 || ce6;
	assign ce4      = !v_s4 || ce5;
	assign ce3      = !v_s3 || ce4;
	assign ce2      = !v_s2 || ce3;
	assign ce1      = !v_s1 || ce2;
	assign s_tready = ce1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (ce1) v_s1 <= s_tvalid;
			if (ce2) v_s2 <= v_s1;
			if (ce3) v_s3 <= v_s2;
			if (ce4) v_s4 <= v_s3;
			// writes leave the pipeline at the stage that writes the intrinsic table
			if (ce5) v_s5 <= v_s4 && (kind_s4 == KIND_POINT);
			if (ce6) v_s6 <= v_s5;
			if (ce7) v_s7 <= v_s6;
			if (ce8) v_s8 <= v_s7;
			if (ce9) v_s9 <= div_out_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// each table is written in the stage that reads it, so order is kept
	always_ff @(posedge clk) begin
		if (ce2 && v_s1 && (kind_s1 == KIND_WRITE) && (idx_s1 < IDX_W'(INTR_BASE))) begin
			ext_q[idx_s1[3:0]] <= val_s1;
		end
		if (ce5 && v_s4 && (kind_s4 == KIND_WRITE) && (idx_s4 >= IDX_W'(INTR_BASE))
				&& (idx_s4 < IDX_W'(COEF_COUNT))) begin
			intr_q[idx_s4[3:0]] <= val_s4;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_c[4*r+c] = PW'(ext_q[4*r+c]) * PW'(pt_s1[c]);
			end
			// homogeneous 1.0 term
			prod_c[4*r+3] = PW'(ext_q[4*r+3]) <<< FRAC_BITS;
		end
		for (int k = 0; k < 8; k++) begin
			ps3_c[k] = SW'(prod_s2[2*k]) + SW'(prod_s2[2*k+1]);
		end
		for (int r = 0; r < 4; r++) begin
			tot4_c[r] = TW'(ps_s3[2*r]) + TW'(ps_s3[2*r+1]);
			sh4_c[r]  = tot4_c[r] >>> FRAC_BITS;
			if (sh4_c[r] > TW'(CAM_MAX)) begin
				cam_c[r] = CAM_MAX;
			end else if (sh4_c[r] < TW'(CAM_MIN)) begin
				cam_c[r] = CAM_MIN;
			end else begin
				cam_c[r] = sh4_c[r][CAM_W-1:0];
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod5_c[4*r+c] = PW'(intr_q[4*r+c]) * PW'(cam_s4[c]);
			end
		end
		for (int k = 0; k < 6; k++) begin
			ps6_c[k] = SW'(prod_s5[2*k]) + SW'(prod_s5[2*k+1]);
		end
		for (int r = 0; r < 3; r++) begin
			tot7_c[r] = TW'(ps_s6[2*r]) + TW'(ps_s6[2*r+1]);
			sh7_c[r]  = tot7_c[r] >>> FRAC_BITS;
			uvw_c[r]  = sh7_c[r][UW-1:0];
		end
		for (int r = 0; r < 3; r++) begin
			mag_c[r] = uvw_s7[r][UW-1] ? (~uvw_s7[r] + UW'(1)) : uvw_s7[r];
		end
	end

	always_ff @(posedge clk) begin
		if (ce1) begin
			kind_s1  <= s_tuser[0];
			idx_s1   <= s_tdata[4:0];
			val_s1   <= s_tdata[36:5];
			pt_s1[0] <= s_tdata[68:37];
			pt_s1[1] <= s_tdata[100:69];
			pt_s1[2] <= s_tdata[132:101];
		end
		if (ce2) begin
			kind_s2 <= kind_s1;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			prod_s2 <= prod_c;
		end
		if (ce3) begin
			kind_s3 <= kind_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			ps_s3   <= ps3_c;
		end
		if (ce4) begin
			kind_s4 <= kind_s3;
			idx_s4  <= idx_s3;
			val_s4  <= val_s3;
			cam_s4  <= cam_c;
		end
		if (ce5) begin
			prod_s5 <= prod5_c;
			for (int r = 0; r < 3; r++) cam_s5[r] <= cam_s4[r];
		end
		if (ce6) begin
			ps_s6  <= ps6_c;
			cam_s6 <= cam_s5;
		end
		if (ce7) begin
			uvw_s7 <= uvw_c;
			cam_s7 <= cam_s6;
		end
		if (ce8) begin
			mag_s8          <= mag_c;
			side_s8.cam_x   <= cam_s7[0];
			side_s8.cam_y   <= cam_s7[1];
			side_s8.cam_z   <= cam_s7[2];
			side_s8.neg_col <= uvw_s7[0][UW-1];
			side_s8.neg_row <= uvw_s7[1][UW-1];
			side_s8.zero    <= (uvw_s7[2] == '0);
		end
	end

	lpcp_div #(
		.AW(UW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.in_ready (div_in_rdy),
		.a_col    (mag_s8[0]),
		.a_row    (mag_s8[1]),
		.d        (mag_s8[2]),
		.side_in  (side_s8),
		.out_valid(div_out_v),
		.out_ready(ce9),
		.q_col    (q_col),
		.q_row    (q_row),
		.ovf_col  (ovf_col),
		.ovf_row  (ovf_row),
		.side_out (side_d)
	);

	// sign the magnitude quotient and clamp to 16 bits
	function automatic logic [PIX_W-1:0] pix_sat(input logic [PIX_W-1:0] q,
			input logic ovf, input logic neg);
		if (neg) begin
			if (ovf || q > {1'b1, {(PIX_W-1){1'b0}}}) return {1'b1, {(PIX_W-1){1'b0}}};
			return ~q + PIX_W'(1);
		end
		if (ovf || q > {1'b0, {(PIX_W-1){1'b1}}}) return {1'b0, {(PIX_W-1){1'b1}}};
		return q;
	endfunction

	always_comb begin
		if (side_d.zero) begin
			col_c  = '0;
			row_c  = '0;
			view_c = 1'b0;
		end else begin
			col_c  = pix_sat(q_col, ovf_col, side_d.neg_col);
			row_c  = pix_sat(q_row, ovf_row, side_d.neg_row);
			view_c = !col_c[PIX_W-1] && !row_c[PIX_W-1]
				&& (PIX_W'(col_c) < PIX_W'(width_q))
				&& (PIX_W'(row_c) < PIX_W'(height_q));
		end
	end

	always_ff @(posedge clk) begin
		if (ce9) begin
			dat_s9 <= {row_c, col_c, side_d.cam_z, side_d.cam_y, side_d.cam_x};
			usr_s9 <= {!side_d.zero, view_c};
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = dat_s9;
	assign m_tuser  = usr_s9;

	// zero depth forces an out-of-view, zero pixel
	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> !m_tuser[0] && (m_tdata[127:96] == '0))
		else $error("zero depth result not cleared");

	// an in-view pixel is nonnegative on both axes
	a_view_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[111] && !m_tdata[127])
		else $error("in-view pixel with negative coordinate");

	// an in-view pixel lies inside the configured image
	a_view_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[111:96] < PIX_W'(width_q)) && (m_tdata[127:112] < PIX_W'(height_q)))
		else $error("in-view pixel outside image bounds");

endmodule

FILE: tb/lidar_point_camera_projection_tb.sv
`timescale 1ns / 1ps

// Expected-result store and projection predictor for the lidar projection block.
// The coefficient table and image size are mirrored here.
class projection_scoreboard;
	typedef struct {
		logic signed [31:0] cam_x, cam_y, cam_z;
		logic signed [15:0] col, row;
		logic               in_view, depth_valid;
	} pixel_result_t;

	int frac;
	logic signed [31:0] coef_tbl [lpcp_pkg::COEF_COUNT];
	longint img_w, img_h;
	pixel_result_t pending [$];
	int errors, points, writes, results, views, zero_depths;

	function new(int f);
		frac = f;
		img_w = lpcp_pkg::WIDTH_RST;
		img_h = lpcp_pkg::HEIGHT_RST;
		foreach (coef_tbl[i]) coef_tbl[i] = '0;
	endfunction

	function void set_size(logic idx, longint v);
		if (idx == lpcp_pkg::REG_WIDTH) img_w = v;
		else img_h = v;
	endfunction

	// exact four-term dot product, floored to frac bits
	function longint dot_row(int base, logic signed [31:0] v0, logic signed [31:0] v1,
			logic signed [31:0] v2, logic signed [31:0] v3);
		logic signed [65:0] acc, a, b;
		logic signed [31:0] vec [4];
		vec[0] = v0; vec[1] = v1; vec[2] = v2; vec[3] = v3;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			a = coef_tbl[base + k];
			b = vec[k];
			acc += a * b;
		end
		return longint'(acc >>> frac);
	endfunction

	function logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function logic signed [15:0] sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// called on every accepted input transaction
	function void note_input(logic kind, logic [4:0] idx, logic signed [31:0] val,
			logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [31:0] one, c [4];
		longint u, v, w, d;
		pixel_result_t r;
		if (kind == lpcp_pkg::KIND_WRITE) begin
			writes++;
			if (idx < lpcp_pkg::COEF_COUNT) coef_tbl[idx] = val;
			return;
		end
		points++;
		one = 32'sd1 <<< frac;
		for (int i = 0; i < 4; i++) c[i] = sat32(dot_row(4 * i, px, py, pz, one));
		u = dot_row(lpcp_pkg::INTR_BASE, c[0], c[1], c[2], c[3]);
		v = dot_row(lpcp_pkg::INTR_BASE + 4, c[0], c[1], c[2], c[3]);
		w = dot_row(lpcp_pkg::INTR_BASE + 8, c[0], c[1], c[2], c[3]);
		r.cam_x = c[0]; r.cam_y = c[1]; r.cam_z = c[2];
		r.col = '0; r.row = '0; r.in_view = 1'b0;
		r.depth_valid = (w != 0);
		if (w != 0) begin
			d = (w < 0) ? -w : w;
			r.col = sat16(u / d);
			r.row = sat16(v / d);
			r.in_view = (r.col >= 0) && (longint'(r.col) < img_w) &&
				(r.row >= 0) && (longint'(r.row) < img_h);
		end else zero_depths++;
		if (r.in_view) views++;
		pending.insert(pending.size(), r);
	endfunction

	// called on every accepted output transaction
	function void check_result(logic [127:0] data, logic [1:0] user);
		pixel_result_t e;
		results++;
		if (pending.size() == 0) begin
			$error("unexpected output transaction %h", data);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (data[31:0] !== e.cam_x) begin
			$error("cam_x exp %h act %h", e.cam_x, data[31:0]); errors++;
		end
		if (data[63:32] !== e.cam_y) begin
			$error("cam_y exp %h act %h", e.cam_y, data[63:32]); errors++;
		end
		if (data[95:64] !== e.cam_z) begin
			$error("cam_z exp %h act %h", e.cam_z, data[95:64]); errors++;
		end
		if (data[111:96] !== e.col) begin
			$error("pixel_col exp %0d act %0d", e.col, $signed(data[111:96])); errors++;
		end
		if (data[127:112] !== e.row) begin
			$error("pixel_row exp %0d act %0d", e.row, $signed(data[127:112])); errors++;
		end
		if (user[0] !== e.in_view) begin
			$error("in_view exp %b act %b", e.in_view, user[0]); errors++;
		end
		if (user[1] !== e.depth_valid) begin
			$error("depth_valid exp %b act %b", e.depth_valid, user[1]); errors++;
		end
	endfunction
endclass

module lidar_point_camera_projection_tb;
	import lpcp_pkg::*;

	localparam int F         = 16;
	localparam int LATENCY   = 26;
	localparam int DRAIN     = LATENCY + 20;   // cycles to let write transactions flush
	localparam int MAX_CYCLE = 400000;
	localparam int PHASE_N   = 6;
	localparam int PER_PHASE = 110;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [0:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0]          m_tuser;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	projection_scoreboard sb = new(F);
	bit  idle_on = 1'b1;     // random gaps on both sides; cleared for the last phase
	int  cycles = 0;
	int  stall_left = 0;

	lidar_point_camera_projection #(.FRAC_BITS(F)) dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// both monitors sample at the edge, before any NBA lands
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tuser[0], s_tdata[4:0], s_tdata[36:5], s_tdata[68:37],
				s_tdata[100:69], s_tdata[132:101]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// receiver back-pressure: random stall bursts
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one transaction on the slave stream; returns at the accepting edge
	task automatic send(logic kind, logic [4:0] idx, logic [31:0] val,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		bit rdy;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, pz, py, px, val, idx};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic put_coef(int idx, logic [31:0] val);
		send(KIND_WRITE, idx[4:0], val, $urandom, $urandom, $urandom);
	endtask

	task automatic put_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send(KIND_POINT, 5'($urandom), $urandom, px, py, pz);
	endtask

	// sender holds off until every expected result is out, then the pipe flushes
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_size(logic idx, logic [CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_size(idx, v);
	endtask

	// nominal calibration: extrinsic is identity plus a small offset,
	// intrinsic has fx = fy = 500, principal point (320, 240)
	function automatic logic [31:0] nominal_coef(int i);
		case (i)
			0, 5, 10, 15: return 32'sd1 <<< F;
			3:  return 32'sd13107;            // 0.2 m
			7:  return -32'sd6554;            // -0.1 m
			16: return 32'sd500 <<< F;
			18: return 32'sd320 <<< F;
			21: return 32'sd500 <<< F;
			22: return 32'sd240 <<< F;
			26: return 32'sd1 <<< F;
			default: return '0;
		endcase
	endfunction

	task automatic load_nominal();
		for (int i = 0; i < COEF_COUNT; i++) put_coef(i, nominal_coef(i));
	endtask

	// small signed coordinate in metres, within plus or minus span_m
	function automatic logic [31:0] near_coord(int span_m);
		return $signed($urandom_range(0, 2 * span_m * 65536)) - span_m * 65536;
	endfunction

	task automatic random_item();
		int pick;
		logic [31:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			// coefficient rewrite, sometimes wild, sometimes a nudge, sometimes out of range
			case ($urandom_range(0, 2))
				0: val = $urandom;
				1: val = nominal_coef(pick) + $urandom_range(0, 8191) - 4096;
				default: val = $signed($urandom_range(0, 4 << F)) - (2 << F);
			endcase
			put_coef($urandom_range(0, 31), val);
		end else if (pick < 30) begin
			put_point($urandom, $urandom, $urandom);
		end else if (pick < 36) begin
			put_point(near_coord(5), near_coord(5), 32'd0);   // lands near zero depth
		end else begin
			put_point(near_coord(30), near_coord(20), $urandom_range(1 << 14, 80 << F));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] widths  [PHASE_N];
		logic [CFG_W-1:0] heights [PHASE_N];
		widths  = '{14'd640, 14'd1, 14'd8192, 14'd16383, 14'd0, 14'd1920};
		heights = '{14'd480, 14'd1, 14'd8192, 14'd0, 14'd16383, 14'd1080};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table load, ignored indexes, zero depth, behind camera, extremes
		load_nominal();
		put_coef(28, 32'hdeadbeef);
		put_coef(31, 32'h7fffffff);
		put_point(32'd0, 32'd0, 32'd0);                          // w == 0
		put_point(32'd0, 32'd0, 32'sd10 <<< F);                  // centre-ish
		put_point(32'sd1 <<< F, 32'sd1 <<< F, -(32'sd5 <<< F));  // behind, |w| divisor
		put_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		put_point(32'h80000000, 32'h80000000, 32'h80000000);
		put_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
		put_point(32'h7fffffff, 32'h80000000, 32'sd1);           // pixel saturation
		put_point(-(32'sd3 <<< F), 32'sd2 <<< F, 32'sd4 <<< F);
		put_coef(0, 32'h7fffffff);                                // cam saturation
		put_point(32'h7fffffff, 32'd0, 32'sd1 <<< F);
		put_coef(0, 32'h80000000);
		put_point(32'h7fffffff, 32'd0, 32'sd1 <<< F);
		put_coef(0, nominal_coef(0));

		for (int ph = 0; ph < PHASE_N; ph++) begin
			idle_on = (ph != PHASE_N - 1);
			if (ph != 0) begin
				write_size(REG_WIDTH, widths[ph]);
				write_size(REG_HEIGHT, heights[ph]);
				load_nominal();
			end
			for (int n = 0; n < PER_PHASE; n++) random_item();
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d points, %0d coefficient writes, %0d results checked",
			sb.points, sb.writes, sb.results);
		$display("  %0d in view, %0d zero depth, %0d image size settings",
			sb.views, sb.zero_depths, PHASE_N);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
